FILE: rtl/core/tdp_pkg.sv
package tdp_pkg;

  // Width of the tested value.
  localparam int VALUE_WIDTH = 31;

  // Bit counter for the serial remainder unit; it holds VALUE_WIDTH itself.
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  // Squared divisor is kept two bits wider than the value so that the step
  // from d*d to (d+2)*(d+2) cannot overflow.
  localparam int SQ_W = VALUE_WIDTH + 2;

  // Request to the remainder unit.
  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [VALUE_WIDTH-1:0] divisor;
  } rem_req_t;

  // Status back from the remainder unit.
  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

endpackage

FILE: rtl/core/tdp_rem.sv
module tdp_rem (
  input  logic             clk,
  input  logic             rst_n,
  input  tdp_pkg::rem_req_t  req,
  output tdp_pkg::rem_stat_t stat
);
  import tdp_pkg::*;

  logic [VALUE_WIDTH-1:0] shreg_r;
  logic [VALUE_WIDTH-1:0] div_r;
  logic [VALUE_WIDTH-1:0] rem_r;
  logic [VALUE_WIDTH-1:0] rem_nxt;
  logic [VALUE_WIDTH:0]   trial;
  logic [CNT_W-1:0]       cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic                   zero_r;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_r, shreg_r[VALUE_WIDTH-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = VALUE_WIDTH'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[VALUE_WIDTH-1:0];
    end
  end

  // Control: one step per dividend bit after a start, then a done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(VALUE_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out MSB first, remainder accumulates.
  always_ff @(posedge clk) begin
    if (req.start) begin
      shreg_r <= req.dividend;
      div_r   <= req.divisor;
      rem_r   <= '0;
    end else if (busy_r) begin
      shreg_r <= {shreg_r[VALUE_WIDTH-2:0], 1'b0};
      rem_r   <= rem_nxt;
      zero_r  <= (rem_nxt == '0);
    end
  end

  assign stat.done = done_r;
  assign stat.zero = zero_r;

endmodule

FILE: rtl/core/trial_division_primality_test_unit.sv
// Trial-division primality test. Each input transfer carries one value; one
// result transfer returns that value and a prime flag. Values 0 and 1 and even
// values above 2 are reported not prime in screening, with no trial division.
// For an odd value n of 3 or more, odd divisors d = 3, 5, 7, ... are tried
// while d*d <= n, and the search stops at the first exact divisor. Each trial
// divisor runs through the bit-serial remainder unit, which produces one
// quotient bit per cycle; the worst case is a large prime, about sqrt(n)/2
// trials. One value is in work at a time; the next input is taken as soon as
// the previous result sits in the output register.
module trial_division_primality_test_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tdp_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tdp_pkg::VALUE_WIDTH-1:0] out_tested_value,
  output logic                            out_is_prime
);
  import tdp_pkg::*;

  state_t                 state_r;
  state_t                 state_nxt;
  logic [VALUE_WIDTH-1:0] n_r;
  logic [VALUE_WIDTH-1:0] d_r;
  logic [SQ_W-1:0]        sq_r;
  logic                   prime_r;
  logic                   prime_nxt;
  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_value_r;
  logic                   out_prime_r;
  logic                   in_xfer;
  logic                   out_load;
  logic                   step;
  rem_req_t               rem_req;
  rem_stat_t              rem_stat;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Sequencer: screen the easy cases, then run one serial remainder per divisor.
  always_comb begin
    state_nxt        = state_r;
    prime_nxt        = prime_r;
    rem_req.start    = 1'b0;
    rem_req.dividend = n_r;
    rem_req.divisor  = d_r;
    step             = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (n_r < VALUE_WIDTH'(2)) begin
          prime_nxt = 1'b0;
          state_nxt = S_DONE;
        end else if (n_r == VALUE_WIDTH'(2)) begin
          prime_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (!n_r[0]) begin
          prime_nxt = 1'b0;
          state_nxt = S_DONE;
        end else if (sq_r > {2'b00, n_r}) begin
          prime_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rem_req.start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) begin
            prime_nxt = 1'b0;
            state_nxt = S_DONE;
          end else begin
            step      = 1'b1;
            state_nxt = S_CHECK;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  tdp_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .stat  (rem_stat)
  );

  // State and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working value, divisor and its square; (d+2)^2 = d^2 + 4d + 4.
  always_ff @(posedge clk) begin
    prime_r <= prime_nxt;
    if (in_xfer) begin
      n_r  <= in_value;
      d_r  <= VALUE_WIDTH'(3);
      sq_r <= SQ_W'(9);
    end else if (step) begin
      d_r  <= d_r + VALUE_WIDTH'(2);
      sq_r <= sq_r + {d_r, 2'b00} + SQ_W'(4);
    end
  end

  // Output register holds the result until its transfer.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= n_r;
      out_prime_r <= prime_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tested_value = out_value_r;
  assign out_is_prime     = out_prime_r;

`ifndef SYNTH
  // An accepted value always goes to the screening state first.
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_CHECK))
    else $error("accepted value did not enter screening");

  // The remainder unit only reports while the sequencer waits for it.
  a_rem_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_stat.done |-> (state_r == S_DIV))
    else $error("remainder result arrived outside division state");

  // Trial divisors are always odd.
  a_divisor_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> d_r[0])
    else $error("even trial divisor");

  // A prime result is odd or equals two.
  a_prime_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_prime) |->
      (out_tested_value[0] || (out_tested_value == VALUE_WIDTH'(2))))
    else $error("even value above two reported prime");
`endif

endmodule

FILE: tb/tdp_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the primality test unit, predicts the result of
// every accepted input transfer and compares each result transfer with the
// oldest prediction still waiting.
module tdp_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [tdp_pkg::VALUE_WIDTH-1:0] in_value,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [tdp_pkg::VALUE_WIDTH-1:0] out_tested_value,
  input  logic                            out_is_prime,
  output int                              mismatch_count,
  output int                              pending_count,
  output int                              checked_count,
  output int                              prime_count
);

  localparam int VW = tdp_pkg::VALUE_WIDTH;

  typedef struct {
    logic [VW-1:0] value;
    logic          prime;
  } prime_result_t;

  prime_result_t pending_results[$];
  prime_result_t oldest;
  int            errors  = 0;
  int            checked = 0;
  int            primes  = 0;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    checked_count  = 0;
    prime_count    = 0;
  end

  // Trial division with odd divisors; the bound d <= n / d stands for d*d <= n.
  function automatic logic predict_prime(logic [VW-1:0] n);
    longint unsigned num;
    longint unsigned div;
    num = n;
    if (num < 2) return 1'b0;
    if (num == 2) return 1'b1;
    if ((num & 1) == 0) return 1'b0;
    for (div = 3; div <= num / div; div += 2) begin
      if (num % div == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Results are checked before a new input is queued, since a result can
  // never belong to an input taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing pending: expected none, actual %0d/%0d",
                   $time, out_tested_value, out_is_prime);
        end else begin
          oldest = pending_results.pop_front();
          checked++;
          if (oldest.prime) primes++;
          if (out_tested_value !== oldest.value) begin
            errors++;
            $display("%0t: tested_value expected %0d, actual %0d",
                     $time, oldest.value, out_tested_value);
          end
          if (out_is_prime !== oldest.prime) begin
            errors++;
            $display("%0t: is_prime for %0d expected %0d, actual %0d",
                     $time, oldest.value, oldest.prime, out_is_prime);
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_results.push_back('{value: in_value, prime: predict_prime(in_value)});
      end
    end
    mismatch_count <= errors;
    pending_count  <= pending_results.size();
    checked_count  <= checked;
    prime_count    <= primes;
  end

endmodule

FILE: tb/trial_division_primality_test_unit_tb.sv
`timescale 1ns / 1ps

// Drives values into the primality test unit with random gaps and result
// stalls, and gives the verdict from the checker's counts.
module trial_division_primality_test_unit_tb;

  localparam int VW          = tdp_pkg::VALUE_WIDTH;
  localparam int RANDOM_ITEMS = 78;
  // The largest prime of the field needs about 23170 trials.
  localparam int IDLE_LIMIT  = 3_000_000;
  localparam int TAIL_CYCLES = 40;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  logic [VW-1:0] in_value  = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [VW-1:0] out_tested_value;
  logic          out_is_prime;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int prime_count;

  logic          quiet       = 1'b0;
  int            stall_left  = 0;
  int            idle_cycles = 0;
  int            directed_sent = 0;
  int            random_sent   = 0;
  logic [VW-1:0] max_value   = {VW{1'b1}};
  int unsigned   small_odd_primes[5] = '{3, 5, 7, 11, 13};
  logic [VW-1:0] directed_values[$];

  trial_division_primality_test_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tested_value (out_tested_value),
    .out_is_prime     (out_is_prime)
  );

  tdp_result_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tested_value (out_tested_value),
    .out_is_prime     (out_is_prime),
    .mismatch_count   (mismatch_count),
    .pending_count    (pending_count),
    .checked_count    (checked_count),
    .prime_count      (prime_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Most values are small so that prime searches stay short; wide values
  // carry a small factor so that the high bits are exercised cheaply.
  function automatic logic [VW-1:0] random_value();
    int            r;
    int unsigned   p;
    int unsigned   q;
    int unsigned   k;
    logic [VW-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 40) return VW'($urandom_range(0, 255));
    if (r < 60) return VW'($urandom_range(256, 65535));
    if (r < 65) return VW'($urandom_range(65536, 1 << 22));
    if (r < 80) begin
      v = VW'($urandom);
      v[0] = 1'b0;
      return v;
    end
    if (r < 95) begin
      p = small_odd_primes[$urandom_range(0, 4)];
      k = $urandom_range(1, 32'(max_value) / p);
      return VW'(p * k);
    end
    // Odd squares land exactly on the d*d == n bound of the search.
    q = 2 * $urandom_range(1, 127) + 1;
    return VW'(q * q);
  endfunction

  // One input transfer, optionally after an idle gap; returns at the
  // accepting edge with valid still high.
  task automatic send_value(logic [VW-1:0] v);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // Result stalls, with quiet stretches where the receiver never holds off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (quiet || $urandom_range(0, 99) < 65) begin
      out_stall <= 1'b0;
    end else begin
      out_stall  <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    directed_values = '{0, 1, 2, 3, 4, 5, 7, 8, 9, 15, 25, 49, 1021, 1023,
                        63001, 65521, 65535, 31'h5555_5555};
    directed_values.push_back(VW'(max_value - 2));
    directed_values.push_back(VW'(max_value - 1));
    directed_values.push_back({1'b1, {(VW-1){1'b0}}});
    // The top of the field is prime and runs the longest search.
    directed_values.push_back(max_value);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed values.
    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
      directed_sent++;
    end

    // Random values, with the pace changed every sixteen transfers.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 16 == 0) quiet <= ($urandom_range(0, 3) == 0);
      send_value(random_value());
      random_sent++;
    end
    in_valid <= 1'b0;
    quiet    <= 1'b1;

    // Drain the results, then watch a while for anything unexpected.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d values (%0d directed, %0d random); checked %0d results, %0d prime.",
             directed_sent + random_sent, directed_sent, random_sent, checked_count,
             prime_count);
    $display("Values spanned zero to the top of the field under random gaps and stalls.");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
